// ===== src/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// shared types, sizes and codes of the max-heap priority queue core
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int CAPACITY   = 1024;
  localparam int KEY_W      = 32;
  localparam int FILL_W     = 11;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = CNT_W + 1;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int STATUS_W   = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_FULL,
    OP_EMPTY
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [KEY_W-1:0] key;
    logic [CNT_W-1:0]        pos;   // insert: new slot, remove: count before
    logic [CNT_W-1:0]        fill;  // count after the transaction
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_INS_CHK,
    B_INS_CMP,
    B_REM_TOP,
    B_REM_TOPW,
    B_REM_LAST,
    B_REM_CHK,
    B_REM_L,
    B_REM_R,
    B_FIN
  } back_state_t;

  // one-based heap slot to zero-based store address
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [IDX_W-1:0] s);
    logic [IDX_W-1:0] a;
    a = s - IDX_W'(1);
    return a[ADDR_W-1:0];
  endfunction

endpackage

// ===== src/mhpq_front.sv =====
// ----------------------------------------------------------------------------
// mhpq_front
// accepts transactions, tracks the fill count and classifies each one
// ----------------------------------------------------------------------------
module mhpq_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic signed [mhpq_pkg::KEY_W-1:0] in_key_in,
  input  logic                              q_full,
  output logic                              q_push,
  output mhpq_pkg::cmd_t                    q_cmd
);

  logic [mhpq_pkg::CNT_W-1:0] count_r, count_nxt;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    count_nxt  = count_r;
    q_cmd.key  = in_key_in;
    q_cmd.pos  = count_r;
    q_cmd.fill = count_r;
    q_cmd.op   = mhpq_pkg::OP_EMPTY;
    if (in_action == mhpq_pkg::ACT_INSERT) begin
      if (count_r >= mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY)) begin
        q_cmd.op = mhpq_pkg::OP_FULL;
      end else begin
        q_cmd.op   = mhpq_pkg::OP_INSERT;
        q_cmd.pos  = count_r + mhpq_pkg::CNT_W'(1);
        q_cmd.fill = count_r + mhpq_pkg::CNT_W'(1);
        count_nxt  = count_r + mhpq_pkg::CNT_W'(1);
      end
    end else if (count_r != '0) begin
      q_cmd.op   = mhpq_pkg::OP_REMOVE;
      q_cmd.fill = count_r - mhpq_pkg::CNT_W'(1);
      count_nxt  = count_r - mhpq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (q_push) begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== src/mhpq_fifo.sv =====
// ----------------------------------------------------------------------------
// mhpq_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module mhpq_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mhpq_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output mhpq_pkg::cmd_t pop_cmd,
  output logic           not_empty
);

  mhpq_pkg::cmd_t               q_r [mhpq_pkg::FIFO_DEPTH];
  logic [mhpq_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [mhpq_pkg::FIFO_CW-1:0] cnt_r;
  logic                         do_push, do_pop;

  assign full      = (cnt_r == mhpq_pkg::FIFO_CW'(mhpq_pkg::FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + mhpq_pkg::FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + mhpq_pkg::FIFO_AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + mhpq_pkg::FIFO_CW'(1);
        2'b01:   cnt_r <= cnt_r - mhpq_pkg::FIFO_CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== src/mhpq_back.sv =====
// ----------------------------------------------------------------------------
// mhpq_back
// heap store and sift sequencer, one store read per cycle, result register
// ----------------------------------------------------------------------------
module mhpq_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cmd_valid,
  input  mhpq_pkg::cmd_t                     cmd,
  output logic                               cmd_pop,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic signed [mhpq_pkg::KEY_W-1:0]  out_key,
  output logic [mhpq_pkg::STATUS_W-1:0]      out_status,
  output logic [mhpq_pkg::FILL_W-1:0]        out_fill
);

  localparam int KW = mhpq_pkg::KEY_W;
  localparam int CW = mhpq_pkg::CNT_W;
  localparam int IW = mhpq_pkg::IDX_W;
  localparam int FW = mhpq_pkg::FILL_W;

  mhpq_pkg::back_state_t state_r, state_nxt;

  // heap store
  logic signed [KW-1:0]           mem [mhpq_pkg::CAPACITY];
  logic                           rd_en, wr_en;
  logic [mhpq_pkg::ADDR_W-1:0]    rd_addr, wr_addr;
  logic signed [KW-1:0]           wr_data, rd_data_r;

  // working registers
  logic signed [KW-1:0]           key_r, key_nxt;
  logic signed [KW-1:0]           moving_r, moving_nxt;
  logic signed [KW-1:0]           left_r, left_nxt;
  logic signed [KW-1:0]           res_key_r, res_key_nxt;
  logic [CW-1:0]                  pos_r, pos_nxt;
  logic [CW-1:0]                  n_r, n_nxt;
  logic [CW-1:0]                  parent_r, parent_nxt;
  logic [IW-1:0]                  child_r, child_nxt;
  logic [CW-1:0]                  fill_r, fill_nxt;
  logic [mhpq_pkg::STATUS_W-1:0]  status_r, status_nxt;

  // result register
  logic                           out_valid_r, out_valid_nxt;
  logic signed [KW-1:0]           out_key_r, out_key_nxt;
  logic [mhpq_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [FW-1:0]                  out_fill_r, out_fill_nxt;

  logic                           out_free;
  logic                           right_exists, child_past_end, right_bigger;
  logic signed [KW-1:0]           sel_key;
  logic [IW-1:0]                  sel_idx;
  logic                           stop;
  logic [IW-1:0]                  pos_w, parent_w, n_w;

  assign pos_w          = {1'b0, pos_r};
  assign parent_w       = {1'b0, parent_r};
  assign n_w            = {1'b0, n_r};
  assign out_free       = !out_valid_r || !out_stall;
  assign child_past_end = child_r > n_w;
  assign right_exists   = (child_r + IW'(1)) <= n_w;
  assign right_bigger   = (state_r == mhpq_pkg::B_REM_R) && (left_r < rd_data_r);
  // larger child, left on a tie
  assign sel_key = (state_r == mhpq_pkg::B_REM_R && !right_bigger) ? left_r : rd_data_r;
  assign sel_idx = right_bigger ? child_r + IW'(1) : child_r;
  assign stop    = moving_r > sel_key;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mhpq_pkg::B_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            mhpq_pkg::OP_INSERT: state_nxt = mhpq_pkg::B_INS_CHK;
            mhpq_pkg::OP_REMOVE: state_nxt = mhpq_pkg::B_REM_TOP;
            default:             state_nxt = mhpq_pkg::B_FIN;
          endcase
        end
      end
      mhpq_pkg::B_INS_CHK: begin
        state_nxt = (pos_r == CW'(1)) ? mhpq_pkg::B_FIN : mhpq_pkg::B_INS_CMP;
      end
      mhpq_pkg::B_INS_CMP: begin
        state_nxt = (key_r > rd_data_r) ? mhpq_pkg::B_INS_CHK : mhpq_pkg::B_FIN;
      end
      mhpq_pkg::B_REM_TOP:  state_nxt = mhpq_pkg::B_REM_TOPW;
      mhpq_pkg::B_REM_TOPW: begin
        state_nxt = (n_r == CW'(1)) ? mhpq_pkg::B_FIN : mhpq_pkg::B_REM_LAST;
      end
      mhpq_pkg::B_REM_LAST: state_nxt = mhpq_pkg::B_REM_CHK;
      mhpq_pkg::B_REM_CHK: begin
        state_nxt = child_past_end ? mhpq_pkg::B_FIN : mhpq_pkg::B_REM_L;
      end
      mhpq_pkg::B_REM_L: begin
        priority if (right_exists) state_nxt = mhpq_pkg::B_REM_R;
        else if (stop)             state_nxt = mhpq_pkg::B_FIN;
        else                       state_nxt = mhpq_pkg::B_REM_CHK;
      end
      mhpq_pkg::B_REM_R: begin
        state_nxt = stop ? mhpq_pkg::B_FIN : mhpq_pkg::B_REM_CHK;
      end
      mhpq_pkg::B_FIN: begin
        if (out_free) state_nxt = mhpq_pkg::B_IDLE;
      end
      default: state_nxt = mhpq_pkg::B_IDLE;
    endcase
  end

  // store control and datapath
  always_comb begin
    cmd_pop        = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = mhpq_pkg::slot_addr(IW'(1));
    wr_en          = 1'b0;
    wr_addr        = mhpq_pkg::slot_addr(parent_w);
    wr_data        = moving_r;
    key_nxt        = key_r;
    moving_nxt     = moving_r;
    left_nxt       = left_r;
    res_key_nxt    = res_key_r;
    pos_nxt        = pos_r;
    n_nxt          = n_r;
    parent_nxt     = parent_r;
    child_nxt      = child_r;
    fill_nxt       = fill_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_key_nxt    = out_key_r;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;
    unique case (state_r)
      mhpq_pkg::B_IDLE: begin
        cmd_pop     = cmd_valid;
        key_nxt     = cmd.key;
        pos_nxt     = cmd.pos;
        n_nxt       = cmd.pos;
        fill_nxt    = cmd.fill;
        res_key_nxt = '0;
        unique case (cmd.op)
          mhpq_pkg::OP_FULL:  status_nxt = mhpq_pkg::ST_FULL;
          mhpq_pkg::OP_EMPTY: status_nxt = mhpq_pkg::ST_EMPTY;
          default:            status_nxt = mhpq_pkg::ST_OK;
        endcase
      end
      mhpq_pkg::B_INS_CHK: begin
        if (pos_r == CW'(1)) begin
          wr_en   = 1'b1;
          wr_addr = mhpq_pkg::slot_addr(pos_w);
          wr_data = key_r;
        end else begin
          rd_en   = 1'b1;
          rd_addr = mhpq_pkg::slot_addr(pos_w >> 1);
        end
      end
      mhpq_pkg::B_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = mhpq_pkg::slot_addr(pos_w);
        if (key_r > rd_data_r) begin
          // parent moves down one level
          wr_data = rd_data_r;
          pos_nxt = pos_r >> 1;
        end else begin
          wr_data = key_r;
        end
      end
      mhpq_pkg::B_REM_TOP: begin
        rd_en = 1'b1;
      end
      mhpq_pkg::B_REM_TOPW: begin
        res_key_nxt = rd_data_r;
        rd_en       = 1'b1;
        rd_addr     = mhpq_pkg::slot_addr(n_w);
      end
      mhpq_pkg::B_REM_LAST: begin
        moving_nxt = rd_data_r;
        n_nxt      = n_r - CW'(1);
        parent_nxt = CW'(1);
        child_nxt  = IW'(2);
      end
      mhpq_pkg::B_REM_CHK: begin
        if (child_past_end) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = mhpq_pkg::slot_addr(child_r);
        end
      end
      mhpq_pkg::B_REM_L, mhpq_pkg::B_REM_R: begin
        if (state_r == mhpq_pkg::B_REM_L) begin
          left_nxt = rd_data_r;
        end
        priority if (state_r == mhpq_pkg::B_REM_L && right_exists) begin
          rd_en   = 1'b1;
          rd_addr = mhpq_pkg::slot_addr(child_r + IW'(1));
        end else if (stop) begin
          wr_en = 1'b1;
        end else begin
          // larger child moves up one level
          wr_en      = 1'b1;
          wr_data    = sel_key;
          parent_nxt = sel_idx[CW-1:0];
          child_nxt  = {sel_idx[IW-2:0], 1'b0};
        end
      end
      mhpq_pkg::B_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_key_nxt    = res_key_r;
          out_status_nxt = status_r;
          out_fill_nxt   = FW'(fill_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mhpq_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    moving_r     <= moving_nxt;
    left_r       <= left_nxt;
    res_key_r    <= res_key_nxt;
    pos_r        <= pos_nxt;
    n_r          <= n_nxt;
    parent_r     <= parent_nxt;
    child_r      <= child_nxt;
    fill_r       <= fill_nxt;
    status_r     <= status_nxt;
    out_key_r    <= out_key_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_key    = out_key_r;
  assign out_status = out_status_r;
  assign out_fill   = out_fill_r;

endmodule

// ===== src/max_heap_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core
// binary max-heap priority queue over signed 32-bit keys
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in_     | input     | in_valid / in_stall | in_action, in_key_in
//  out_    | output    | out_valid/out_stall | out_key_out, out_status,
//          |           |                     | out_fill_level
//
//  steps: an accepted transaction is registered in the command queue and
//    waits there until the back is idle; once popped, an insert reads the
//    parent and moves it one level down while the key is larger, then
//    writes the key where it lands; a remove reads the root as its result
//    and, unless that was the last entry, moves the last entry to the root
//    and sifts it down, reading the left and, if present, the right child
//    per level; full and empty rejects go straight to the result register.
//    the heap store has a single read port: one read per sift-up level,
//    one or two per sift-down level, each registered
//  reset: rst_n low clears the fill count, the command queue and the
//    sequencer; the heap store is not cleared, empty slots are never read
//  stalls: the front keeps taking transactions into a four-entry queue while
//    the back works; a stalled result holds the back only at its last step
//
module max_heap_priority_queue_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_action,
  input  logic signed [mhpq_pkg::KEY_W-1:0]    in_key_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mhpq_pkg::KEY_W-1:0]    out_key_out,
  output logic [mhpq_pkg::STATUS_W-1:0]        out_status,
  output logic [mhpq_pkg::FILL_W-1:0]          out_fill_level
);

  // front to queue
  logic           q_full;
  logic           q_push;
  mhpq_pkg::cmd_t q_push_cmd;

  // queue to back
  logic           q_not_empty;
  logic           q_pop;
  mhpq_pkg::cmd_t q_pop_cmd;

  // front: classifies each transaction against its own fill count
  mhpq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_key_in (in_key_in),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_push_cmd)
  );

  // decoupling queue
  mhpq_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (q_pop_cmd),
    .not_empty (q_not_empty)
  );

  // back: sift sequencer over the heap store, owns the result register
  mhpq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_not_empty),
    .cmd        (q_pop_cmd),
    .cmd_pop    (q_pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_key    (out_key_out),
    .out_status (out_status),
    .out_fill   (out_fill_level)
  );

  // only a successful remove carries a key
  a_key_zero_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != mhpq_pkg::ST_OK) |-> (out_key_out == '0))
    else $error("nonzero key on a rejected transaction");

  // an empty reject leaves the heap empty
  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == mhpq_pkg::ST_EMPTY) |-> (out_fill_level == '0))
    else $error("empty status with nonzero fill level");

  // a full reject leaves the heap at capacity
  a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == mhpq_pkg::ST_FULL)
      |-> (out_fill_level == mhpq_pkg::FILL_W'(mhpq_pkg::CAPACITY)))
    else $error("full status below capacity");

  // the back never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("command popped from empty queue");

endmodule
